// ===== rtl/rgblab_pkg.sv =====
// Package for the RGB to CIELAB pixel unit: fixed-point formats, matrix
// coefficients, companding constants and the stage enable type.
// Depends on nothing; every module of the unit imports it.
`timescale 1ns / 1ps
package rgblab_pkg;

   localparam int unsigned CRT_DEPTH_DEFAULT = 1024;
   localparam int unsigned PIX_WIDTH = 8;
   localparam int unsigned V_WIDTH = 24;
   localparam int unsigned F_WIDTH = 17;
   localparam int unsigned L_WIDTH = 15;
   localparam int unsigned AB_WIDTH = 16;
   localparam int unsigned COEF_WIDTH = 16;

   localparam logic [COEF_WIDTH-1:0] MAT_Q24 [3][3] = '{
      '{16'd28551, 16'd24753, 16'd12489},
      '{16'd13992, 16'd47053, 16'd4748},
      '{16'd1168, 16'd7202, 16'd57417}
   };

   localparam logic [V_WIDTH-1:0] LIN_THRESH = 24'd148579;
   localparam logic [18:0] LIN_SLOPE = 19'd510331;
   localparam logic [F_WIDTH-1:0] LIN_OFFSET = 17'd9039;
   localparam logic [17:0] L_SLOPE_LIN = 18'd231245;
   localparam int L_MAX = 25600;

   typedef logic [V_WIDTH-1:0] v_type;
   typedef logic [F_WIDTH-1:0] f_type;

   typedef struct packed {
      logic s2;
      logic s3;
   } stage_en_type;

endpackage

// ===== rtl/rgblab_crt_rom.sv =====
// Cube-root ROM with two registered read ports for adjacent entries.
// Content is U1.16, computed at elaboration. Depends on rgblab_pkg.
`timescale 1ns / 1ps
module rgblab_crt_rom #(
   parameter int unsigned DEPTH = rgblab_pkg::CRT_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         read_en,
   input  logic [$clog2(DEPTH)-1:0]     addr,
   output logic [rgblab_pkg::F_WIDTH-1:0] lo_data,
   output logic [rgblab_pkg::F_WIDTH-1:0] hi_data
);
   import rgblab_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH + 1);

   typedef f_type rom_type [DEPTH+1];

   function automatic rom_type build_rom();
      rom_type t;
      logic [63:0] target;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      for (int i = 0; i <= int'(DEPTH); i++) begin
         target = 64'(i) << 48;
         lo = 64'd0;
         hi = 64'd65536;
         while (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            if (mid * mid * mid * 64'(DEPTH) <= target) begin
               lo = mid;
            end else begin
               hi = mid - 64'd1;
            end
         end
         t[i] = F_WIDTH'(lo);
      end
      return t;
   endfunction

   localparam rom_type ROM = build_rom();

   logic [AW-1:0] addr_lo;
   logic [AW-1:0] addr_hi;

   assign addr_lo = AW'(addr);
   assign addr_hi = AW'(addr) + AW'(1);

   always_ff @(posedge clock) begin
      if (read_en) begin
         lo_data <= ROM[addr_lo];
         hi_data <= ROM[addr_hi];
      end
   end

endmodule

// ===== rtl/rgblab_compand.sv =====
// CIELAB companding for one channel: table address and linear branch in one
// stage, table interpolation in the next. Depends on rgblab_pkg, rgblab_crt_rom.
`timescale 1ns / 1ps
module rgblab_compand #(
   parameter int unsigned DEPTH = rgblab_pkg::CRT_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  rgblab_pkg::stage_en_type en,
   input  rgblab_pkg::v_type        v,
   output rgblab_pkg::f_type        f_ff,
   output logic                     cube_ff
);
   import rgblab_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned PW = V_WIDTH + $clog2(DEPTH + 1);

   logic [PW-1:0]      p;
   logic [AW-1:0]      idx;
   logic [42:0]        lin_prod;
   f_type              lin_in;
   logic               cube_in;
   logic [V_WIDTH-1:0] fr_ff;
   f_type              lin_ff;
   logic               cube2_ff;
   f_type              lo_data;
   f_type              hi_data;
   f_type              diff;
   logic [40:0]        interp;
   f_type              f_in;

   assign p = PW'(v) * PW'(DEPTH);
   assign idx = p[V_WIDTH +: AW];
   assign lin_prod = 43'(v) * 43'(LIN_SLOPE) + 43'(24'h800000);
   assign lin_in = F_WIDTH'(lin_prod[42:24]) + LIN_OFFSET;
   assign cube_in = v > LIN_THRESH;

   rgblab_crt_rom #(.DEPTH(DEPTH)) u_rom (
      .clock   (clock),
      .read_en (en.s2),
      .addr    (idx),
      .lo_data (lo_data),
      .hi_data (hi_data)
   );

   always_ff @(posedge clock) begin
      if (en.s2) begin
         fr_ff <= p[V_WIDTH-1:0];
         lin_ff <= lin_in;
         cube2_ff <= cube_in;
      end
   end

   assign diff = hi_data - lo_data;
   assign interp = 41'(diff) * 41'(fr_ff);
   assign f_in = cube2_ff ? lo_data + F_WIDTH'(interp[40:24]) : lin_ff;

   always_ff @(posedge clock) begin
      if (en.s3) begin
         f_ff <= f_in;
         cube_ff <= cube2_ff;
      end
   end

endmodule

// ===== rtl/rgb_to_cielab_pixel_unit.sv =====
// Top level of the RGB to CIELAB (D65) pixel unit: matrix stage, three
// companding channels and the L, a, b output stage. Depends on rgblab_pkg,
// rgblab_compand.
//
// One pixel beat is accepted per clock unless back-pressure holds the stages,
// and each result passes through the matrix stage, the registered cube-root ROM
// read, the interpolation multiply and the output register. Every stage has
// its own valid bit and loads whenever it is empty or its successor loads,
// so back-pressure stalls only what is behind a held result.
`timescale 1ns / 1ps
module rgb_to_cielab_pixel_unit #(
   parameter int unsigned CUBE_ROOT_TABLE_DEPTH = rgblab_pkg::CRT_DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [rgblab_pkg::PIX_WIDTH-1:0]        req_red_in,
   input  logic [rgblab_pkg::PIX_WIDTH-1:0]        req_green_in,
   input  logic [rgblab_pkg::PIX_WIDTH-1:0]        req_blue_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [rgblab_pkg::L_WIDTH-1:0]          rsp_lightness,
   output logic signed [rgblab_pkg::AB_WIDTH-1:0]  rsp_green_red_axis,
   output logic signed [rgblab_pkg::AB_WIDTH-1:0]  rsp_blue_yellow_axis
);
   import rgblab_pkg::*;

   logic         v1_ff, v2_ff, v3_ff, v4_ff;
   logic         en1, en4;
   stage_en_type en;
   v_type        v_in [3];
   v_type        v_ff [3];
   f_type        f [3];
   logic         cube [3];
   logic [41:0]  lum_prod;
   logic [L_WIDTH-1:0] lum_lin2_ff, lum_lin3_ff;
   logic signed [18:0] fx_s, fy_s, fz_s;
   logic signed [31:0] lum_n, lum_c, lum_v, a_n, b_n, a_q, b_q;
   logic [L_WIDTH-1:0] lum_in;
   logic signed [AB_WIDTH-1:0] a_in, b_in;
   logic [L_WIDTH-1:0] lum_ff;
   logic signed [AB_WIDTH-1:0] a_ff, b_ff;

   assign en4 = !v4_ff || rsp_ready;
   assign en.s3 = !v3_ff || en4;
   assign en.s2 = !v2_ff || en.s3;
   assign en1 = !v1_ff || en.s2;
   assign req_ready = en1;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         v_in[r] = V_WIDTH'(26'(MAT_Q24[r][0]) * 26'(req_red_in)
                 + 26'(MAT_Q24[r][1]) * 26'(req_green_in)
                 + 26'(MAT_Q24[r][2]) * 26'(req_blue_in));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en.s2) v2_ff <= v1_ff;
         if (en.s3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         v_ff <= v_in;
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_chan
      rgblab_compand #(.DEPTH(CUBE_ROOT_TABLE_DEPTH)) u_compand (
         .clock   (clock),
         .en      (en),
         .v       (v_ff[c]),
         .f_ff    (f[c]),
         .cube_ff (cube[c])
      );
   end

   assign lum_prod = 42'(v_ff[1]) * 42'(L_SLOPE_LIN) + 42'(24'h800000);

   always_ff @(posedge clock) begin
      if (en.s2) lum_lin2_ff <= lum_prod[24 +: L_WIDTH];
      if (en.s3) lum_lin3_ff <= lum_lin2_ff;
   end

   always_comb begin
      fx_s = signed'(19'(f[0]));
      fy_s = signed'(19'(f[1]));
      fz_s = signed'(19'(f[2]));
      lum_n = 32'sd116 * signed'(32'(f[1])) + 32'sd128;
      lum_c = (lum_n >>> 8) - 32'sd4096;
      lum_v = cube[1] ? lum_c : signed'(32'(lum_lin3_ff));
      if (lum_v < 0) begin
         lum_in = '0;
      end else if (lum_v > L_MAX) begin
         lum_in = L_WIDTH'(L_MAX);
      end else begin
         lum_in = L_WIDTH'(lum_v);
      end
      a_n = 32'sd500 * 32'(fx_s - fy_s) + 32'sd128;
      b_n = 32'sd200 * 32'(fy_s - fz_s) + 32'sd128;
      a_q = a_n >>> 8;
      b_q = b_n >>> 8;
      if (a_q > 32'sd32767) a_in = 16'sh7fff;
      else if (a_q < -32'sd32768) a_in = 16'sh8000;
      else a_in = AB_WIDTH'(a_q);
      if (b_q > 32'sd32767) b_in = 16'sh7fff;
      else if (b_q < -32'sd32768) b_in = 16'sh8000;
      else b_in = AB_WIDTH'(b_q);
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         lum_ff <= lum_in;
         a_ff <= a_in;
         b_ff <= b_in;
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_lightness = lum_ff;
   assign rsp_green_red_axis = a_ff;
   assign rsp_blue_yellow_axis = b_ff;

   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready) else $error("input stalled while output drains");
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v1_ff) else $error("accepted beat lost");
   a_exit: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && en4) |=> rsp_valid) else $error("result lost at output");
   a_lum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_lightness <= L_WIDTH'(L_MAX))) else $error("L out of range");

endmodule

// ===== dv/tb_rgb_to_cielab_pixel_unit.sv =====
// Self-checking testbench for the RGB to CIELAB pixel unit: drives pixel beats,
// computes the expected L, a, b in fixed point and compares each result beat.
// Depends on rgblab_pkg and rgb_to_cielab_pixel_unit.
`timescale 1ns / 1ps
module tb_rgb_to_cielab_pixel_unit;
   import rgblab_pkg::*;

   localparam int unsigned DEPTH = CRT_DEPTH_DEFAULT;

   typedef struct {
      logic [L_WIDTH-1:0] lightness;
      logic signed [AB_WIDTH-1:0] green_red;
      logic signed [AB_WIDTH-1:0] blue_yellow;
   } lab_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [PIX_WIDTH-1:0] req_red_in = '0;
   logic [PIX_WIDTH-1:0] req_green_in = '0;
   logic [PIX_WIDTH-1:0] req_blue_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [L_WIDTH-1:0] rsp_lightness;
   logic signed [AB_WIDTH-1:0] rsp_green_red_axis;
   logic signed [AB_WIDTH-1:0] rsp_blue_yellow_axis;

   longint unsigned cube_root_rom [DEPTH+1];
   lab_type expected_lab [$];
   int error_count = 0;
   bit quiet_mode = 1'b0;

   rgb_to_cielab_pixel_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_red_in(req_red_in), .req_green_in(req_green_in),
      .req_blue_in(req_blue_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_lightness(rsp_lightness), .rsp_green_red_axis(rsp_green_red_axis),
      .rsp_blue_yellow_axis(rsp_blue_yellow_axis)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #50_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic void fill_cube_root_rom();
      longint unsigned lo, hi, mid;
      for (int i = 0; i <= DEPTH; i++) begin
         lo = 0;
         hi = 65536;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid * mid * DEPTH <= (longint'(i) << 48)) lo = mid;
            else hi = mid - 1;
         end
         cube_root_rom[i] = lo;
      end
   endfunction

   function automatic longint compand(longint unsigned v);
      longint unsigned p, idx, fr, lo, hi;
      if (v > LIN_THRESH) begin
         p = v * DEPTH;
         idx = p >> 24;
         fr = p & 64'hFFFFFF;
         if (idx >= DEPTH) idx = DEPTH - 1;
         lo = cube_root_rom[idx];
         hi = cube_root_rom[idx+1];
         return longint'(lo + (((hi - lo) * fr) >> 24));
      end
      return longint'(((v * LIN_SLOPE + (64'd1 << 23)) >> 24) + LIN_OFFSET);
   endfunction

   function automatic longint floor_div256(longint n);
      if (n >= 0) return n / 256;
      return -((-n + 255) / 256);
   endfunction

   function automatic longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic lab_type predict_lab(logic [7:0] red, logic [7:0] green,
                                           logic [7:0] blue);
      longint unsigned v [3];
      longint fx, fy, fz, lum;
      lab_type res;
      for (int r = 0; r < 3; r++)
         v[r] = longint'(MAT_Q24[r][0]) * red + longint'(MAT_Q24[r][1]) * green
              + longint'(MAT_Q24[r][2]) * blue;
      fx = compand(v[0]);
      fy = compand(v[1]);
      fz = compand(v[2]);
      if (v[1] > LIN_THRESH) lum = floor_div256(116 * fy + 128) - 4096;
      else lum = longint'((v[1] * L_SLOPE_LIN + (64'd1 << 23)) >> 24);
      if (lum < 0) lum = 0;
      if (lum > L_MAX) lum = L_MAX;
      res.lightness = lum[L_WIDTH-1:0];
      res.green_red = AB_WIDTH'(clamp16(floor_div256(500 * (fx - fy) + 128)));
      res.blue_yellow = AB_WIDTH'(clamp16(floor_div256(200 * (fy - fz) + 128)));
      return res;
   endfunction

   task automatic send_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      while (!quiet_mode && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_red_in <= red;
      req_green_in <= green;
      req_blue_in <= blue;
      do @(posedge clock); while (!req_ready);
      expected_lab.push_back(predict_lab(red, green, blue));
      @(negedge clock);
   endtask

   always @(negedge clock)
      rsp_ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 25);

   always @(posedge clock) begin
      lab_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_lab.size() == 0) begin
            $display("%0t: result beat with nothing expected: %0d %0d %0d", $time,
                     rsp_lightness, rsp_green_red_axis, rsp_blue_yellow_axis);
            error_count++;
         end else begin
            want = expected_lab.pop_front();
            if (rsp_lightness !== want.lightness) begin
               $display("%0t: lightness expected %0d actual %0d", $time,
                        want.lightness, rsp_lightness);
               error_count++;
            end
            if (rsp_green_red_axis !== want.green_red) begin
               $display("%0t: green_red_axis expected %0d actual %0d", $time,
                        want.green_red, rsp_green_red_axis);
               error_count++;
            end
            if (rsp_blue_yellow_axis !== want.blue_yellow) begin
               $display("%0t: blue_yellow_axis expected %0d actual %0d", $time,
                        want.blue_yellow, rsp_blue_yellow_axis);
               error_count++;
            end
         end
      end
   end

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_lab.size() != 0) @(negedge clock);
   endtask

   task automatic test_corners();
      logic [7:0] corner [4] = '{8'd0, 8'd1, 8'd128, 8'd255};
      for (int r = 0; r < 4; r++)
         for (int g = 0; g < 4; g += 3)
            for (int b = 0; b < 4; b += 3)
               send_pixel(corner[r], corner[g], corner[b]);
      // Pixels near the companding threshold and alternating-bit values.
      send_pixel(8'd0, 8'd3, 8'd0);
      send_pixel(8'd0, 8'd4, 8'd0);
      send_pixel(8'd3, 8'd3, 8'd3);
      send_pixel(8'd85, 8'd170, 8'd85);
      send_pixel(8'd170, 8'd85, 8'd170);
   endtask

   task automatic test_random_pixels(int count);
      for (int i = 0; i < count; i++)
         if ($urandom_range(3) == 0)
            send_pixel(8'($urandom_range(8)), 8'($urandom_range(8)),
                       8'($urandom_range(8)));
         else
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic test_full_rate(int count);
      quiet_mode = 1'b1;
      test_random_pixels(count);
      wait_drained();
      quiet_mode = 1'b0;
   endtask

   initial begin
      fill_cube_root_rom();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_corners();
      test_random_pixels(250);
      wait_drained();
      test_full_rate(150);
      test_random_pixels(200);
      wait_drained();
      repeat (20) @(negedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/rgblab_pkg.sv
rtl/rgblab_crt_rom.sv
rtl/rgblab_compand.sv
rtl/rgb_to_cielab_pixel_unit.sv
dv/tb_rgb_to_cielab_pixel_unit.sv
